>>> src/cqmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqmm_pkg
// Shared widths, codes and controller/datapath interface types for the
// circular queue with min/max queries.
// ----------------------------------------------------------------------------
package cqmm_pkg;

  // payload widths and default ring depth
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 4;
  localparam int DEPTH_DEF = 16;

  // operation codes carried on the input tuser
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd3;

  // status codes carried on the output tuser
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // which result the output register takes
  typedef enum logic [2:0] {
    RES_ADD,
    RES_FULL,
    RES_EMPTY,
    RES_POP,
    RES_SCAN
  } cqmm_res_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic      push;      // write value at tail, advance tail
    logic      rd_start;  // read at head, scan pointer to the slot after head
    logic      rd_step;   // read at scan pointer, advance it
    logic      scan_upd;  // fold the returned word into the running best
    logic      pop;       // advance head
    logic      res_load;  // load the output register
    cqmm_res_t res_kind;
  } cqmm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_end;       // scan pointer has reached tail
  } cqmm_stat_t;

endpackage

>>> src/circular_queue_with_min_max_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_min_max_unit
// Ring-buffer queue of signed 32-bit words (DEPTH slots, DEPTH-1 usable)
// with add, remove and maximum/minimum queries.
// ----------------------------------------------------------------------------
// One operation word in gives exactly one result word out. Add, and any
// full or empty reply, loads the output register from idle; remove goes
// through a pop state as the ring sits in a memory with a registered read
// port; a max or min query has the single read port walk the entries from
// head to tail one per cycle, each folded through one 32-bit compare. The
// block returns to idle after each operation and takes the next word as
// soon as the output register is free or being drained, so a finished
// result that waits on the output holds off the next input.
// Storage contents are not cleared at reset; only head and tail are, so
// the block is ready as soon as reset is released.
module circular_queue_with_min_max_unit #(
  parameter int DEPTH = cqmm_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,   // value[31:0]
  input  logic [cqmm_pkg::MODE_W-1:0] s_tuser,   // mode[1:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,   // data[31:0], count[35:32], zero[39:36]
  output logic [cqmm_pkg::STAT_W-1:0] m_tuser    // status[1:0]
);
  import cqmm_pkg::*;

  cqmm_cmd_t                cmd;
  cqmm_stat_t               stat;
  logic signed [DATA_W-1:0] data;
  logic [CNT_W-1:0]         count;

  // sequencer
  cqmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and compare
  cqmm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .mode   (s_tuser),
    .value  (s_tdata),
    .data   (data),
    .status (m_tuser),
    .count  (count)
  );

  // output word packing
  assign m_tdata = {4'b0000, count, data};

endmodule

>>> src/cqmm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqmm_ctrl
// Sequencer for the queue: decodes each accepted operation, walks the
// stored words for min/max queries and owns the output word valid.
// ----------------------------------------------------------------------------
module cqmm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [cqmm_pkg::MODE_W-1:0] mode,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  cqmm_pkg::cqmm_stat_t        stat,
  output cqmm_pkg::cqmm_cmd_t         cmd
);
  import cqmm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;
  logic       take;

  // a new word may enter only when the output slot is empty or draining
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;
  assign take      = s_tvalid && s_tready;

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.res_kind = RES_ADD;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (mode)
            MODE_ADD: begin
              cmd.res_load = 1'b1;
              if (stat.full) begin
                cmd.res_kind = RES_FULL;
              end else begin
                cmd.push     = 1'b1;
                cmd.res_kind = RES_ADD;
              end
            end
            MODE_REM: begin
              if (stat.empty) begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_EMPTY;
              end else begin
                cmd.rd_start = 1'b1;
                state_next   = S_POP;
              end
            end
            default: begin
              if (stat.empty) begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_EMPTY;
              end else begin
                cmd.rd_start = 1'b1;
                state_next   = S_SCAN;
              end
            end
          endcase
        end
      end
      S_POP: begin
        cmd.pop      = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_POP;
        state_next   = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_SCAN;
          state_next   = S_IDLE;
        end else begin
          cmd.rd_step  = 1'b1;
          cmd.scan_upd = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // the output slot is empty while an operation is still being worked on
  a_busy_slot_empty: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !m_tvalid)
    else $error("output word pending while busy");

  // a result never overwrites a word that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> slot_free)
    else $error("result loaded over a pending word");

  // a remove finishes in the cycle after the read
  a_pop_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (state == S_IDLE))
    else $error("remove did not return to idle");
`endif

endmodule

>>> src/cqmm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqmm_dp
// Datapath: ring storage with one write and one registered read port,
// head/tail/scan pointers, the running min/max compare and the output
// register.
// ----------------------------------------------------------------------------
module cqmm_dp #(
  parameter int DEPTH = cqmm_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cqmm_pkg::cqmm_cmd_t                cmd,
  output cqmm_pkg::cqmm_stat_t               stat,
  input  logic [cqmm_pkg::MODE_W-1:0]        mode,
  input  logic signed [cqmm_pkg::DATA_W-1:0] value,
  output logic signed [cqmm_pkg::DATA_W-1:0] data,
  output logic [cqmm_pkg::STAT_W-1:0]        status,
  output logic [cqmm_pkg::CNT_W-1:0]         count
);
  import cqmm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (AW > CNT_W) ? AW : CNT_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   RING = (AW + 1)'(DEPTH);

  logic [DATA_W-1:0]        mem [DEPTH];
  logic [AW-1:0]            head;
  logic [AW-1:0]            tail;
  logic [AW-1:0]            head_next;
  logic [AW-1:0]            tail_next;
  logic [AW-1:0]            tail_inc;
  logic [AW-1:0]            head_inc;
  logic [AW-1:0]            scan_idx;
  logic [AW-1:0]            scan_inc;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] best;
  logic signed [DATA_W-1:0] cand;
  logic signed [DATA_W-1:0] res_data;
  logic [STAT_W-1:0]        res_status;
  logic                     first;
  logic                     want_max;
  logic                     better;
  logic [AW:0]              diff;
  logic [AW-1:0]            cnt;
  logic [CW-1:0]            cnt_ext;

  // ring increments
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;
  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign scan_inc = (scan_idx == LAST) ? '0 : scan_idx + 1'b1;

  // status to the controller
  assign stat.empty    = (head == tail);
  assign stat.full     = (tail_inc == head);
  assign stat.scan_end = (scan_idx == tail);

  // pointer updates
  assign tail_next = cmd.push ? tail_inc : tail;
  assign head_next = cmd.pop ? head_inc : head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // storage, read data registered
  assign rd_addr = cmd.rd_start ? head : scan_idx;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= value;
    end
    rdata <= mem[rd_addr];
  end

  // scan pointer and running best
  assign better = want_max ? (rdata > best) : (rdata < best);
  assign cand   = (first || better) ? rdata : best;

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      scan_idx <= head_inc;
      first    <= 1'b1;
      want_max <= (mode == MODE_MAX);
    end else if (cmd.rd_step) begin
      scan_idx <= scan_inc;
    end
    if (cmd.scan_upd) begin
      best  <= cand;
      first <= 1'b0;
    end
  end

  // entries held after the operation
  always_comb begin
    diff = {1'b0, tail_next} - {1'b0, head_next};
    if (tail_next >= head_next) begin
      cnt = diff[AW-1:0];
    end else begin
      cnt = AW'(diff + RING);
    end
    cnt_ext = CW'(cnt);
  end

  // result select
  always_comb begin
    unique case (cmd.res_kind)
      RES_ADD: begin
        res_data   = '0;
        res_status = ST_OK;
      end
      RES_FULL: begin
        res_data   = '0;
        res_status = ST_FULL;
      end
      RES_EMPTY: begin
        res_data   = '0;
        res_status = ST_EMPTY;
      end
      RES_POP: begin
        res_data   = rdata;
        res_status = ST_OK;
      end
      RES_SCAN: begin
        res_data   = cand;
        res_status = ST_OK;
      end
      default: begin
        res_data   = '0;
        res_status = ST_OK;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      data   <= res_data;
      status <= res_status;
      count  <= cnt_ext[CNT_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // never write into a full ring
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full)
    else $error("push into full queue");

  // never advance head past tail
  a_pop_held: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty)
    else $error("pop from empty queue");

  // the scan never reads beyond the last held entry
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_step |-> !stat.scan_end)
    else $error("scan read past tail");
`endif

endmodule

>>> tb/circular_queue_with_min_max_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_min_max_unit_test
// Self-checking bench for the ring-buffer queue with max/min queries.
// A directed opening exercises empty and full replies, extreme words and
// ties. Random bursts that lean towards filling, draining or mixing follow.
// Every accepted input word runs through a queue model kept here. Each
// output word is checked field by field against the oldest prediction,
// under changing idle patterns on both sides and one long output stall.
// ----------------------------------------------------------------------------
module circular_queue_with_min_max_unit_test;
  import cqmm_pkg::*;

  localparam int RING_SLOTS   = DEPTH_DEF;
  localparam int RANDOM_OPS   = 525;
  localparam int PHASE1_AT    = 190;
  localparam int PHASE2_AT    = 380;
  localparam int STALL_AT     = 420;
  localparam int STALL_CYCLES = 250;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic signed [31:0] value;
  } queue_op_t;

  typedef struct {
    logic signed [31:0] data;
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   count;
  } queue_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;
  logic [MODE_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [39:0]         m_tdata;
  logic [STAT_W-1:0]   m_tuser;

  circular_queue_with_min_max_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // value[31:0]
    .s_tuser  (s_tuser),   // mode[1:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // data[31:0], count[35:32], zero[39:36]
    .m_tuser  (m_tuser)    // status[1:0]
  );

  // queue model state
  logic signed [31:0] ring_mem [RING_SLOTS];
  int                 ring_head = 0;
  int                 ring_tail = 0;

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];

  int n_total    = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_full     = 0;
  int n_empty    = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  // apply one operation to the model queue and work out its reply
  task automatic apply_queue_op(input queue_op_t op, output queue_result_t res);
    int                 next_tail;
    int                 slot;
    int                 held;
    logic signed [31:0] best;
    res.data   = '0;
    res.status = ST_OK;
    next_tail  = (ring_tail + 1) % RING_SLOTS;
    case (op.mode)
      MODE_ADD: begin
        if (next_tail == ring_head) begin
          res.status = ST_FULL;
        end else begin
          ring_mem[ring_tail] = op.value;
          ring_tail = next_tail;
        end
      end
      MODE_REM: begin
        if (ring_head == ring_tail) begin
          res.status = ST_EMPTY;
        end else begin
          res.data  = ring_mem[ring_head];
          ring_head = (ring_head + 1) % RING_SLOTS;
        end
      end
      default: begin
        if (ring_head == ring_tail) begin
          res.status = ST_EMPTY;
        end else begin
          // walk head to tail, first word met wins on a tie
          best = ring_mem[ring_head];
          slot = (ring_head + 1) % RING_SLOTS;
          while (slot != ring_tail) begin
            if (op.mode == MODE_MAX ? (ring_mem[slot] > best) : (ring_mem[slot] < best))
              best = ring_mem[slot];
            slot = (slot + 1) % RING_SLOTS;
          end
          res.data = best;
        end
      end
    endcase
    held = (ring_tail + RING_SLOTS - ring_head) % RING_SLOTS;
    res.count = held[CNT_W-1:0];
  endtask

  task automatic queue_word(input logic [MODE_W-1:0] mode, input logic [31:0] value);
    queue_op_t op;
    op.mode  = mode;
    op.value = value;
    pending_ops.push_back(op);
    n_total++;
  endtask

  // value mix: extremes, a narrow band for ties, and full-range words
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // idle percentages per phase
  function automatic int send_idle_pct(input int accepted);
    if (accepted < PHASE1_AT) return 9;
    if (accepted < PHASE2_AT) return 70;
    return 0;
  endfunction

  function automatic int recv_idle_pct(input int accepted);
    if (accepted < PHASE1_AT) return 70;
    if (accepted < PHASE2_AT) return 9;
    return 0;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // stimulus: directed opening, then random bursts
  initial begin
    int burst_kind;
    int burst_len;
    int roll;
    int made;
    logic [MODE_W-1:0] mode;
    // empty replies on every reading operation
    queue_word(MODE_REM, 32'hffff_ffff);
    queue_word(MODE_MAX, 32'h0000_0000);
    queue_word(MODE_MIN, 32'h1234_5678);
    // extreme words
    queue_word(MODE_ADD, 32'h8000_0000);
    queue_word(MODE_ADD, 32'h7fff_ffff);
    queue_word(MODE_ADD, 32'hffff_ffff);
    queue_word(MODE_ADD, 32'h0000_0000);
    queue_word(MODE_MAX, 32'h0);
    queue_word(MODE_MIN, 32'h0);
    queue_word(MODE_REM, 32'h0);
    // ties, then fill up to one short of the ring size
    for (int i = 0; i < 6; i++) queue_word(MODE_ADD, 32'd5);
    for (int i = 0; i < 6; i++) queue_word(MODE_ADD, 32'(i) - 32'd3);
    queue_word(MODE_ADD, 32'h5555_5555);
    queue_word(MODE_MAX, 32'h0);
    queue_word(MODE_MIN, 32'h0);

    made = 0;
    while (made < RANDOM_OPS) begin
      burst_kind = $urandom_range(0, 2);
      burst_len  = $urandom_range(4, 20);
      for (int k = 0; k < burst_len; k++) begin
        roll = $urandom_range(0, 99);
        case (burst_kind)
          0:       mode = roll < 65 ? MODE_ADD : roll < 80 ? MODE_REM :
                          roll < 90 ? MODE_MAX : MODE_MIN;
          1:       mode = roll < 25 ? MODE_ADD : roll < 75 ? MODE_REM :
                          roll < 88 ? MODE_MAX : MODE_MIN;
          default: mode = roll < 40 ? MODE_ADD : roll < 70 ? MODE_REM :
                          roll < 85 ? MODE_MAX : MODE_MIN;
        endcase
        queue_word(mode, mode == MODE_ADD ? pick_value() : $urandom);
        made++;
      end
    end
  end

  // reset
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin
    queue_op_t     op;
    queue_result_t res;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        op.mode  = s_tuser;
        op.value = s_tdata;
        apply_queue_op(op, res);
        expected_results.push_back(res);
        n_accepted <= n_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct(n_accepted)) begin
          op = pending_ops.pop_front();
          s_tuser  <= op.mode;
          s_tdata  <= op.value;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output stall once the sender has stopped idling
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (!stall_done && n_accepted >= STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (stall_left == 0) &&
                  ($urandom_range(0, 99) >= recv_idle_pct(n_accepted));
    end
  end

  // monitor: check each output word against the oldest prediction
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word data %h status %0d count %0d",
                 $time, m_tdata[31:0], m_tuser, m_tdata[35:32]);
        n_errors <= n_errors + 1;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[31:0] !== want.data || m_tuser !== want.status ||
            m_tdata[35:32] !== want.count || m_tdata[39:36] !== 4'd0) begin
          $display("%0t: mismatch expected data %h status %0d count %0d pad 0",
                   $time, want.data, want.status, want.count);
          $display("%0t:          actual   data %h status %0d count %0d pad %h",
                   $time, m_tdata[31:0], m_tuser, m_tdata[35:32], m_tdata[39:36]);
          n_errors <= n_errors + 1;
        end
        if (want.status == ST_FULL) n_full <= n_full + 1;
        if (want.status == ST_EMPTY) n_empty <= n_empty + 1;
      end
      n_checked <= n_checked + 1;
    end
  end

  // end of run
  initial begin
    @(negedge rst);
    while (n_total == 0 || n_accepted != n_total || n_checked < n_total)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d predicted words never arrived", $time, expected_results.size());
      n_errors = n_errors + 1;
    end
    $display("%0d operation words checked, %0d full replies, %0d empty replies,",
             n_checked, n_full, n_empty);
    $display("under three idle patterns and one %0d-cycle output stall", STALL_CYCLES);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("%0t: timeout", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
src/cqmm_pkg.sv
src/cqmm_ctrl.sv
src/cqmm_dp.sv
src/circular_queue_with_min_max_unit.sv
tb/circular_queue_with_min_max_unit_test.sv
